>>> hw/rtl/gjd_pkg.sv
// Shared constants and helper functions for the Gregorian / Julian day converter.
// Used by the core pipeline. No dependencies.
`default_nettype none

package gjd_pkg;

	localparam int unsigned STAGES = 20;

	localparam logic [22:0] JDN_BIAS   = 23'd32075;
	localparam logic [22:0] JAN_TERM   = 23'd336;

	// Reciprocal constants for truncating division of a magnitude by a constant:
	// q = (x * MUL) >> SH, with SH >= bits(x) + bits(divisor).
	localparam int unsigned D100_SH  = 22;
	localparam logic [15:0] D100_MUL = 16'(((64'd1 << D100_SH) + 64'd99) / 64'd100);
	localparam int unsigned N_SH     = 44;
	localparam logic [26:0] N_MUL    = 27'(((64'd1 << N_SH) + 64'd146096) / 64'd146097);
	localparam int unsigned I_SH     = 49;
	localparam logic [28:0] I_MUL    = 29'(((64'd1 << I_SH) + 64'd1461000) / 64'd1461001);
	localparam int unsigned J_SH     = 28;
	localparam logic [16:0] J_MUL    = 17'(((64'd1 << J_SH) + 64'd2446) / 64'd2447);
	localparam int unsigned D80_SH   = 22;
	localparam logic [15:0] D80_MUL  = 16'(((64'd1 << D80_SH) + 64'd79) / 64'd80);

	// Month part of the day count: 367 * (m - 2 - 12a) / 12, where a is -1 for
	// January and February (and months 0) and 0 otherwise.
	function automatic logic [8:0] month_term(input logic [3:0] m);
		logic [8:0] t;
		case (m)
			4'd0:    t = 9'd305;
			4'd1:    t = 9'd336;
			4'd2:    t = 9'd367;
			4'd3:    t = 9'd30;
			4'd4:    t = 9'd61;
			4'd5:    t = 9'd91;
			4'd6:    t = 9'd122;
			4'd7:    t = 9'd152;
			4'd8:    t = 9'd183;
			4'd9:    t = 9'd214;
			4'd10:   t = 9'd244;
			4'd11:   t = 9'd275;
			4'd12:   t = 9'd305;
			4'd13:   t = 9'd336;
			4'd14:   t = 9'd367;
			default: t = 9'd397;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gjd_in_if.sv
// Request channel of the day converter: valid/ready handshake and date payload.
// No dependencies.
`default_nettype none

interface gjd_in_if;
	logic               valid;
	logic               ready;
	logic [3:0]         in_month;
	logic [4:0]         in_day;
	logic [13:0]        in_year;
	logic signed [21:0] day_offset;

	modport source (output valid, output in_month, output in_day, output in_year,
		output day_offset, input ready);
	modport sink (input valid, input in_month, input in_day, input in_year,
		input day_offset, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gjd_out_if.sv
// Result channel of the day converter: valid/ready handshake and converted fields.
// No dependencies.
`default_nettype none

interface gjd_out_if;
	logic               valid;
	logic               ready;
	logic [22:0]        base_jdn;
	logic [8:0]         year_day;
	logic [3:0]         out_month;
	logic [4:0]         out_day;
	logic signed [14:0] out_year;

	modport source (output valid, output base_jdn, output year_day, output out_month,
		output out_day, output out_year, input ready);
	modport sink (input valid, input base_jdn, input year_day, input out_month,
		input out_day, input out_year, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gregorian_julian_day_convert_core.sv
// Throughput: one request per cycle while the output is not stalled; the 20-stage
// pipeline is set by the chain of constant-reciprocal multiplies in the day-number
// to date conversion.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears only the stage valid bits; data registers are not reset.
// Depends on gjd_pkg, gjd_in_if and gjd_out_if.
`default_nettype none

module gregorian_julian_day_convert_core (
	input  logic      clk,
	input  logic      arst_n,
	gjd_in_if.sink    req,
	gjd_out_if.source res
);

	localparam int unsigned NS = gjd_pkg::STAGES;

	logic          advance;
	logic [NS-1:0] vld_q;

	assign advance   = res.ready || !vld_q[NS-1];
	assign req.ready = advance;
	assign res.valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (advance) begin
			vld_q <= {vld_q[NS-2:0], req.valid};
		end
	end

	// Stage registers.
	logic [14:0]        ya_s1, yb_s1, yfa_s1, yfb_s1;
	logic [8:0]         t2_s1;
	logic [4:0]         d_s1;
	logic signed [21:0] off_s1, off_s2, off_s3, off_s4;
	logic [22:0]        t1_s2, t1f_s2;
	logic [7:0]         q_s2, qf_s2;
	logic [9:0]         base_s2;
	logic [22:0]        suma_s3, sumf_s3;
	logic [22:0]        jdn_s4;
	logic [8:0]         yday_s4;
	logic [31:0]        info_q [16];
	logic signed [24:0] l_s5, l_s6, l_s7, l_s8, l_s9;
	logic               lneg_s6, nneg_s7;
	logic [23:0]        lmag_s6;
	logic [8:0]         nq_s7;
	logic signed [9:0]  n_s8;
	logic signed [9:0]  n_line_q [9];
	logic signed [27:0] p_s9;
	logic signed [17:0] l2_s10, l2_s11, l2_s12, l2_s13;
	logic               ineg_s11, ineg_s12;
	logic [27:0]        imag_s11;
	logic [6:0]         iq_s12;
	logic signed [7:0]  i_s13, i_s14, i_s15, i_s16, i_s17;
	logic signed [10:0] l3_s14, l3_s15, l3_s16, l3_s17, l3_s18, l3_s19;
	logic               jneg_s15, jneg_s16;
	logic [15:0]        jmag_s15;
	logic [3:0]         jq_s16;
	logic signed [5:0]  j_s17;
	logic               kneg_s18, kneg_s19;
	logic [14:0]        kmag_s18;
	logic [8:0]         kq_s19;
	logic [3:0]         month_s18, month_s19, month_s20;
	logic [14:0]        year_s18, year_s19, year_s20;
	logic [4:0]         day_s20;

	// Combinational terms.
	logic               a_neg;
	logic [24:0]        t1_p, t1f_p;
	logic [29:0]        q_p, qf_p;
	logic [9:0]         t3_p, t3f_p;
	logic [52:0]        n_p;
	logic signed [27:0] pa;
	logic signed [27:0] l2_diff;
	logic signed [28:0] y1_v;
	logic [56:0]        i_p;
	logic signed [18:0] ti, ta, l3_diff;
	logic signed [16:0] x_v;
	logic [32:0]        j_p;
	logic signed [15:0] kp_v;
	logic signed [1:0]  l4;
	logic signed [16:0] yr_v;
	logic [30:0]        k_p;
	logic signed [10:0] kd, k_v;

	always_comb begin
		a_neg   = (req.in_month <= 4'd2);
		t1_p    = 25'(ya_s1) * 25'd1461;
		t1f_p   = 25'(yfa_s1) * 25'd1461;
		q_p     = 30'(yb_s1) * 30'(gjd_pkg::D100_MUL);
		qf_p    = 30'(yfb_s1) * 30'(gjd_pkg::D100_MUL);
		t3_p    = 10'(q_s2) * 10'd3;
		t3f_p   = 10'(qf_s2) * 10'd3;
		n_p     = 53'({lmag_s6, 2'b00}) * 53'(gjd_pkg::N_MUL);
		pa      = p_s9 + (p_s9[27] ? 28'sd3 : 28'sd0);
		l2_diff = 28'(l_s9) - (pa >>> 2);
		y1_v    = (29'(l2_s10) + 29'sd1) * 29'sd4000;
		i_p     = 57'(imag_s11) * 57'(gjd_pkg::I_MUL);
		ti      = 19'(i_s13) * 19'sd1461;
		ta      = ti + (ti[18] ? 19'sd3 : 19'sd0);
		l3_diff = 19'(l2_s13) - (ta >>> 2) + 19'sd31;
		x_v     = 17'(l3_s14) * 17'sd80;
		j_p     = 33'(jmag_s15) * 33'(gjd_pkg::J_MUL);
		kp_v    = 16'(j_s17) * 16'sd2447;
		if (j_s17 >= 6'sd11) begin
			l4 = 2'sd1;
		end else if (j_s17 <= -6'sd11) begin
			l4 = -2'sd1;
		end else begin
			l4 = 2'sd0;
		end
		yr_v    = (17'(n_line_q[8]) - 17'sd49) * 17'sd100 + 17'(i_s17) + 17'(l4);
		k_p     = 31'(kmag_s18) * 31'(gjd_pkg::D80_MUL);
		kd      = kneg_s19 ? -11'(kq_s19) : 11'(kq_s19);
		k_v     = l3_s19 - kd;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			// Day number of the date and of 1 January of its year.
			ya_s1   <= 15'(req.in_year) + (a_neg ? 15'd4799 : 15'd4800);
			yb_s1   <= 15'(req.in_year) + (a_neg ? 15'd4899 : 15'd4900);
			yfa_s1  <= 15'(req.in_year) + 15'd4799;
			yfb_s1  <= 15'(req.in_year) + 15'd4899;
			t2_s1   <= gjd_pkg::month_term(req.in_month);
			d_s1    <= req.in_day;
			off_s1  <= req.day_offset;

			t1_s2   <= t1_p[24:2];
			t1f_s2  <= t1f_p[24:2];
			q_s2    <= q_p[gjd_pkg::D100_SH +: 8];
			qf_s2   <= qf_p[gjd_pkg::D100_SH +: 8];
			base_s2 <= 10'(t2_s1) + 10'(d_s1);
			off_s2  <= off_s1;

			suma_s3 <= t1_s2 + 23'(base_s2) - 23'(t3_p[9:2]);
			sumf_s3 <= t1f_s2 + gjd_pkg::JAN_TERM - 23'(t3f_p[9:2]);
			off_s3  <= off_s2;

			// The January sum leaves out its day of 1, which cancels the plus one.
			jdn_s4  <= suma_s3 - gjd_pkg::JDN_BIAS;
			yday_s4 <= suma_s3[8:0] - sumf_s3[8:0];
			off_s4  <= off_s3;

			info_q[0] <= {jdn_s4, yday_s4};
			for (int s = 1; s < 16; s++) begin
				info_q[s] <= info_q[s-1];
			end

			// Inverse conversion of the shifted day number.
			l_s5     <= 25'(jdn_s4) + 25'(off_s4) + 25'd68569;

			lneg_s6  <= l_s5[24];
			lmag_s6  <= l_s5[24] ? 24'(-l_s5) : 24'(l_s5);
			l_s6     <= l_s5;

			nq_s7    <= n_p[52:gjd_pkg::N_SH];
			nneg_s7  <= lneg_s6;
			l_s7     <= l_s6;

			n_s8     <= nneg_s7 ? -10'(nq_s7) : 10'(nq_s7);
			l_s8     <= l_s7;

			p_s9     <= 28'(n_s8) * 28'sd146097 + 28'sd3;
			l_s9     <= l_s8;
			n_line_q[0] <= n_s8;
			for (int s = 1; s < 9; s++) begin
				n_line_q[s] <= n_line_q[s-1];
			end

			l2_s10   <= l2_diff[17:0];

			ineg_s11 <= y1_v[28];
			imag_s11 <= y1_v[28] ? 28'(-y1_v) : 28'(y1_v);
			l2_s11   <= l2_s10;

			iq_s12   <= i_p[gjd_pkg::I_SH +: 7];
			ineg_s12 <= ineg_s11;
			l2_s12   <= l2_s11;

			i_s13    <= ineg_s12 ? -8'(iq_s12) : 8'(iq_s12);
			l2_s13   <= l2_s12;

			l3_s14   <= l3_diff[10:0];
			i_s14    <= i_s13;

			jneg_s15 <= x_v[16];
			jmag_s15 <= x_v[16] ? 16'(-x_v) : 16'(x_v);
			l3_s15   <= l3_s14;
			i_s15    <= i_s14;

			jq_s16   <= j_p[gjd_pkg::J_SH +: 4];
			jneg_s16 <= jneg_s15;
			l3_s16   <= l3_s15;
			i_s16    <= i_s15;

			j_s17    <= jneg_s16 ? -6'(jq_s16) : 6'(jq_s16);
			l3_s17   <= l3_s16;
			i_s17    <= i_s16;

			kneg_s18 <= kp_v[15];
			kmag_s18 <= kp_v[15] ? 15'(-kp_v) : 15'(kp_v);
			month_s18 <= 4'(j_s17 + 6'sd2 - 6'(l4) * 6'sd12);
			year_s18 <= yr_v[14:0];
			l3_s18   <= l3_s17;

			kq_s19   <= k_p[gjd_pkg::D80_SH +: 9];
			kneg_s19 <= kneg_s18;
			month_s19 <= month_s18;
			year_s19 <= year_s18;
			l3_s19   <= l3_s18;

			day_s20  <= k_v[4:0];
			month_s20 <= month_s19;
			year_s20 <= year_s19;
		end
	end

	assign res.base_jdn  = info_q[15][31:9];
	assign res.year_day  = info_q[15][8:0];
	assign res.out_month = month_s20;
	assign res.out_day   = day_s20;
	assign res.out_year  = year_s20;

	// A held result must stop new requests from entering.
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |-> !req.ready)
		else $error("request taken while result stalled");

	// Every day number the forward formula can produce lies above this floor.
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.base_jdn >= 23'd1720000)
		else $error("day number below reachable range");

	// An empty pipeline always accepts.
	assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[NS-1] |-> req.ready)
		else $error("empty pipeline refused a request");

endmodule

`default_nettype wire
